@@ rtl/core/rnn_tanh_cell_sequence_macros.svh @@
// Assertion macros used by the checker module of the recurrent cell block.
`ifndef RNN_TANH_CELL_SEQUENCE_MACROS_SVH
`define RNN_TANH_CELL_SEQUENCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define RTCS_ASSERT_ALW(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/rtcs_pkg.sv @@
// Package with the constants, codes and activation table of the recurrent cell block.
package rtcs_pkg;

   localparam int OP_WIDTH           = 2;
   localparam int ADDR_WIDTH         = 13;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 16;
   localparam int COUNT_WIDTH        = 7;
   localparam int BATCH_COUNT_WIDTH  = 4;
   localparam int STEP_WIDTH         = 16;
   localparam int BATCH_INDEX_WIDTH  = 3;
   localparam int HIDDEN_INDEX_WIDTH = 6;

   localparam logic [OP_WIDTH-1:0] OP_WEIGHT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_BIAS   = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_HIDDEN = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_SAMPLE = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INPUT_COUNT     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HIDDEN_COUNT    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BATCH_COUNT     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SEQUENCE_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUTPUT_STEPS    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BIAS_ENABLED    = 3'd5;

   localparam int FRAC_BITS   = 11;
   localparam int ONE_Q       = 2048;
   localparam int HALF_Q      = ONE_Q / 2;
   localparam int SAT_LIMIT   = 8192;
   localparam int Q_WIDTH     = 13;
   localparam int SEG_BITS    = 6;
   localparam int TANH_POINTS = 129;
   localparam int TANH_WIDTH  = 12;
   localparam int SEG_WIDTH   = 8;

   localparam longint unsigned EXP_ONE  = 64'd16777216;
   localparam longint unsigned EXP_STEP = 64'd17859253;

   typedef logic [TANH_WIDTH-1:0] tanh_table_type [TANH_POINTS];

   // Unsigned quotient by shift and subtract, used only while the table is built.
   function automatic longint unsigned quotient_u64(longint unsigned n, longint unsigned d);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n[i]};
         if (rem >= d) begin
            rem    = rem - d;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Points tanh(k/32) in unsigned Q1.11, built from a running power of e^(1/16) in Q24.
   function automatic tanh_table_type build_tanh_table();
      tanh_table_type  t;
      longint unsigned p;
      longint unsigned num;
      longint unsigned den;
      p = EXP_ONE;
      for (int k = 0; k < TANH_POINTS; k++) begin
         num  = (p - EXP_ONE) * 64'(ONE_Q);
         den  = p + EXP_ONE;
         t[k] = TANH_WIDTH'(quotient_u64(num * 64'd2 + den, den * 64'd2));
         p    = (p * EXP_STEP + (64'd1 << 23)) >> 24;
      end
      return t;
   endfunction

   localparam tanh_table_type TANH_TABLE = build_tanh_table();

endpackage

@@ rtl/core/rnn_tanh_cell_sequence.sv @@
// Top level of the sequential fixed-point tanh recurrent cell.
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_op, req_address, req_value
//  rsp      out  rsp_valid/rsp_ready  step, batch, hidden index, hidden value, last
//  csr      in   csr_valid/csr_ready  csr_index, csr_data
//
// A row end runs one multiply-accumulate per cycle through the single weight memory
// read port, then copies the new vector unit by unit (read, write, and an output
// state that waits for the result to be taken when the step is emitted).
// After reset a clearing pass zeroes the hidden stores while no item is taken.
// Each result waits in the output register until taken, and no new item is taken
// while a row is in work.
module rnn_tanh_cell_sequence #(
   parameter int INPUT_MAX  = 64,
   parameter int HIDDEN_MAX = 64,
   parameter int BATCH_MAX  = 8,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [rtcs_pkg::OP_WIDTH-1:0]            req_op,
   input  logic [rtcs_pkg::ADDR_WIDTH-1:0]          req_address,
   input  logic signed [DATA_WIDTH-1:0]             req_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [rtcs_pkg::STEP_WIDTH-1:0]          rsp_step_index,
   output logic [rtcs_pkg::BATCH_INDEX_WIDTH-1:0]   rsp_batch_index,
   output logic [rtcs_pkg::HIDDEN_INDEX_WIDTH-1:0]  rsp_hidden_index,
   output logic signed [DATA_WIDTH-1:0]             rsp_hidden_value,
   output logic                                     rsp_last,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [rtcs_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [rtcs_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import rtcs_pkg::*;

   localparam int WEIGHT_DEPTH = (INPUT_MAX + HIDDEN_MAX) * HIDDEN_MAX;
   localparam int ROWS_DEPTH   = BATCH_MAX * HIDDEN_MAX;
   localparam int WAW  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int HRW  = (ROWS_DEPTH > 1) ? $clog2(ROWS_DEPTH) : 1;
   localparam int SIDX = (INPUT_MAX > 1) ? $clog2(INPUT_MAX) : 1;
   localparam int HIDX = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
   localparam int BW   = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
   localparam int IC_W = $clog2(INPUT_MAX + 1);
   localparam int HC_W = $clog2(HIDDEN_MAX + 1);
   localparam int KW   = $clog2(INPUT_MAX + HIDDEN_MAX + 1);
   localparam int ACC_W = 2 * DATA_WIDTH + $clog2(INPUT_MAX + HIDDEN_MAX + 1) + 2;
   localparam int IP_W = TANH_WIDTH + SEG_BITS + 1;
   localparam int ST_W = 4;

   localparam logic [ST_W-1:0] ST_CLEAR  = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
   localparam logic [ST_W-1:0] ST_MAC    = 4'd2;
   localparam logic [ST_W-1:0] ST_BIAS   = 4'd3;
   localparam logic [ST_W-1:0] ST_ACT1   = 4'd4;
   localparam logic [ST_W-1:0] ST_ACT2   = 4'd5;
   localparam logic [ST_W-1:0] ST_ACT3   = 4'd6;
   localparam logic [ST_W-1:0] ST_CP_RD  = 4'd7;
   localparam logic [ST_W-1:0] ST_CP_WR  = 4'd8;
   localparam logic [ST_W-1:0] ST_CP_OUT = 4'd9;

   logic signed [DATA_WIDTH-1:0] weight_mem [WEIGHT_DEPTH];
   logic signed [DATA_WIDTH-1:0] bias_mem   [HIDDEN_MAX];
   logic signed [DATA_WIDTH-1:0] init_mem   [HIDDEN_MAX];
   logic signed [DATA_WIDTH-1:0] rows_mem   [ROWS_DEPTH];
   logic signed [DATA_WIDTH-1:0] sample_mem [INPUT_MAX];
   logic signed [DATA_WIDTH-1:0] fresh_mem  [HIDDEN_MAX];

   logic signed [DATA_WIDTH-1:0] weight_rd_ff, bias_rd_ff, init_rd_ff;
   logic signed [DATA_WIDTH-1:0] rows_rd_ff, sample_rd_ff, fresh_rd_ff;

   logic [ST_W-1:0]              state_ff, state_in;
   logic [HRW-1:0]               clr_ff, clr_in;
   logic [COUNT_WIDTH-1:0]       cfg_input_count_ff, cfg_hidden_count_ff;
   logic [BATCH_COUNT_WIDTH-1:0] cfg_batch_count_ff;
   logic [STEP_WIDTH-1:0]        cfg_sequence_length_ff, cfg_output_steps_ff;
   logic                         cfg_bias_enabled_ff;
   logic [IC_W-1:0]              elem_ff, elem_in;
   logic [BW-1:0]                batch_ff, batch_in, cur_b_ff, cur_b_in;
   logic [STEP_WIDTH-1:0]        step_ff, step_in;
   logic                         emit_ff, emit_in;
   logic [HC_W-1:0]              j_ff, j_in;
   logic [KW-1:0]                k_ff, k_in;
   logic                         v1_ff, v1_in, v2_ff, v2_in;
   logic                         is_sample_ff, is_sample_in;
   logic signed [2*DATA_WIDTH-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic                         neg_ff, neg_in, sat_ff, sat_in;
   logic [Q_WIDTH-1:0]           q_ff, q_in;
   logic [TANH_WIDTH-1:0]        lo_ff, lo_in, d_ff, d_in;
   logic [SEG_BITS-1:0]          fr_ff, fr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [STEP_WIDTH-1:0]        out_step_ff, out_step_in;
   logic [BATCH_INDEX_WIDTH-1:0] out_batch_ff, out_batch_in;
   logic [HIDDEN_INDEX_WIDTH-1:0] out_index_ff, out_index_in;
   logic signed [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   logic                         out_last_ff, out_last_in;

   logic [IC_W-1:0]       ic;
   logic [HC_W-1:0]       hc;
   logic [BATCH_COUNT_WIDTH-1:0] bc;
   logic [STEP_WIDTH-1:0] sl;
   logic [BW-1:0]         b_now;
   logic                  req_fire, issuing, advance;
   logic [WAW-1:0]        w_raddr;
   logic [SIDX-1:0]       s_raddr;
   logic [HIDX-1:0]       p_raddr, j_idx;
   logic [HRW-1:0]        r_raddr, r_waddr;
   logic signed [DATA_WIDTH-1:0] mult_x;
   logic [ACC_W-1:0]      mag, qsum;
   logic [SEG_WIDTH-1:0]  seg;
   logic [TANH_WIDTH-1:0] t_lo, t_hi;
   logic [IP_W-1:0]       interp;
   logic [Q_WIDTH-1:0]    y_mag;
   logic signed [DATA_WIDTH-1:0] y_ext, y_val;
   logic                  w_we, b_we, i_we, s_we, r_we, f_we;
   logic [HIDX-1:0]       i_waddr;
   logic signed [DATA_WIDTH-1:0] i_wdata, r_wdata;

   always_comb begin
      if (cfg_input_count_ff == '0) begin
         ic = IC_W'(1);
      end else if (32'(cfg_input_count_ff) > INPUT_MAX) begin
         ic = IC_W'(INPUT_MAX);
      end else begin
         ic = IC_W'(cfg_input_count_ff);
      end
      if (cfg_hidden_count_ff == '0) begin
         hc = HC_W'(1);
      end else if (32'(cfg_hidden_count_ff) > HIDDEN_MAX) begin
         hc = HC_W'(HIDDEN_MAX);
      end else begin
         hc = HC_W'(cfg_hidden_count_ff);
      end
      if (cfg_batch_count_ff == '0) begin
         bc = BATCH_COUNT_WIDTH'(1);
      end else if (32'(cfg_batch_count_ff) > BATCH_MAX) begin
         bc = BATCH_COUNT_WIDTH'(BATCH_MAX);
      end else begin
         bc = cfg_batch_count_ff;
      end
      sl = (cfg_sequence_length_ff == '0) ? STEP_WIDTH'(1) : cfg_sequence_length_ff;
   end

   assign req_fire  = req_valid && req_ready;
   assign b_now     = (32'(batch_ff) < BATCH_MAX) ? batch_ff : '0;
   assign issuing   = (state_ff == ST_MAC) && (32'(k_ff) < 32'(ic) + 32'(hc));
   assign j_idx     = HIDX'(j_ff);
   assign w_raddr   = WAW'(32'(k_ff) * HIDDEN_MAX + 32'(j_ff));
   assign s_raddr   = SIDX'(k_ff);
   assign p_raddr   = HIDX'(32'(k_ff) - 32'(ic));
   assign r_raddr   = HRW'(32'(cur_b_ff) * HIDDEN_MAX + 32'(p_raddr));
   assign r_waddr   = HRW'(32'(cur_b_ff) * HIDDEN_MAX + 32'(j_idx));
   assign mult_x    = is_sample_ff ? sample_rd_ff : ((step_ff == '0) ? init_rd_ff : rows_rd_ff);
   assign prod_in   = mult_x * weight_rd_ff;
   assign mag       = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign qsum      = (mag + ACC_W'(HALF_Q)) >> FRAC_BITS;
   assign seg       = {1'b0, q_ff[Q_WIDTH-1:SEG_BITS]};
   assign t_lo      = TANH_TABLE[seg];
   assign t_hi      = TANH_TABLE[seg + SEG_WIDTH'(1)];
   assign interp    = IP_W'(d_ff) * IP_W'(fr_ff) + IP_W'(32);
   assign y_mag     = sat_ff ? Q_WIDTH'(ONE_Q)
                             : Q_WIDTH'(lo_ff) + Q_WIDTH'(interp >> SEG_BITS);
   assign y_ext     = DATA_WIDTH'(y_mag);
   assign y_val     = neg_ff ? -y_ext : y_ext;
   assign advance   = (state_ff == ST_CP_WR && !emit_ff)
                   || (state_ff == ST_CP_OUT && rsp_ready);

   assign w_we    = req_fire && req_op == OP_WEIGHT && 32'(req_address) < WEIGHT_DEPTH;
   assign b_we    = req_fire && req_op == OP_BIAS && 32'(req_address) < HIDDEN_MAX;
   assign s_we    = req_fire && req_op == OP_SAMPLE && 32'(req_address) < INPUT_MAX;
   assign f_we    = state_ff == ST_ACT3;
   assign i_we    = (req_fire && req_op == OP_HIDDEN && 32'(req_address) < HIDDEN_MAX)
                 || (state_ff == ST_CLEAR && 32'(clr_ff) < HIDDEN_MAX);
   assign i_waddr = (state_ff == ST_CLEAR) ? HIDX'(clr_ff) : HIDX'(req_address);
   assign i_wdata = (state_ff == ST_CLEAR) ? '0 : req_value;
   assign r_we    = state_ff == ST_CLEAR || state_ff == ST_CP_WR;
   assign r_wdata = (state_ff == ST_CLEAR) ? '0 : fresh_rd_ff;

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[WAW'(req_address)] <= req_value;
      end
      weight_rd_ff <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_mem[HIDX'(req_address)] <= req_value;
      end
      bias_rd_ff <= bias_mem[j_idx];
   end

   always_ff @(posedge clock) begin
      if (i_we) begin
         init_mem[i_waddr] <= i_wdata;
      end
      init_rd_ff <= init_mem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         rows_mem[(state_ff == ST_CLEAR) ? clr_ff : r_waddr] <= r_wdata;
      end
      rows_rd_ff <= rows_mem[r_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sample_mem[SIDX'(req_address)] <= req_value;
      end
      sample_rd_ff <= sample_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fresh_mem[j_idx] <= y_val;
      end
      fresh_rd_ff <= fresh_mem[j_idx];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      elem_in      = elem_ff;
      batch_in     = batch_ff;
      cur_b_in     = cur_b_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      j_in         = j_ff;
      k_in         = issuing ? k_ff + KW'(1) : k_ff;
      v1_in        = issuing;
      v2_in        = v1_ff;
      is_sample_in = 32'(k_ff) < 32'(ic);
      acc_in       = v2_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      q_in         = q_ff;
      lo_in        = t_lo;
      d_in         = t_hi - t_lo;
      fr_in        = q_ff[SEG_BITS-1:0];
      rsp_valid_in = rsp_valid_ff;
      out_step_in  = out_step_ff;
      out_batch_in = out_batch_ff;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + HRW'(1);
            if (32'(clr_ff) == ROWS_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && req_op == OP_SAMPLE) begin
               if (32'(elem_ff) + 1 < 32'(ic)) begin
                  elem_in = elem_ff + IC_W'(1);
               end else begin
                  elem_in  = '0;
                  cur_b_in = b_now;
                  emit_in  = (17'(step_ff) + 17'(cfg_output_steps_ff)) >= 17'(sl);
                  j_in     = '0;
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (!issuing && !v1_ff && !v2_ff) begin
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: begin
            if (cfg_bias_enabled_ff) begin
               acc_in = acc_ff + (ACC_W'(bias_rd_ff) <<< FRAC_BITS);
            end
            state_in = ST_ACT1;
         end
         ST_ACT1: begin
            neg_in   = acc_ff[ACC_W-1];
            sat_in   = qsum >= ACC_W'(SAT_LIMIT);
            q_in     = Q_WIDTH'(qsum);
            state_in = ST_ACT2;
         end
         ST_ACT2: begin
            state_in = ST_ACT3;
         end
         ST_ACT3: begin
            k_in   = '0;
            acc_in = '0;
            if (32'(j_ff) + 1 < 32'(hc)) begin
               j_in     = j_ff + HC_W'(1);
               state_in = ST_MAC;
            end else begin
               j_in     = '0;
               state_in = ST_CP_RD;
            end
         end
         ST_CP_RD: begin
            state_in = ST_CP_WR;
         end
         ST_CP_WR: begin
            if (emit_ff) begin
               rsp_valid_in = 1'b1;
               out_step_in  = step_ff;
               out_batch_in = BATCH_INDEX_WIDTH'(cur_b_ff);
               out_index_in = HIDDEN_INDEX_WIDTH'(j_ff);
               out_value_in = fresh_rd_ff;
               out_last_in  = 32'(j_ff) + 1 == 32'(hc);
               state_in     = ST_CP_OUT;
            end
         end
         ST_CP_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (advance) begin
         if (32'(j_ff) + 1 < 32'(hc)) begin
            j_in     = j_ff + HC_W'(1);
            state_in = ST_CP_RD;
         end else begin
            j_in     = '0;
            state_in = ST_IDLE;
            if (32'(cur_b_ff) + 1 < 32'(bc)) begin
               batch_in = cur_b_ff + BW'(1);
            end else begin
               batch_in = '0;
               step_in  = (32'(step_ff) + 1 < 32'(sl)) ? step_ff + STEP_WIDTH'(1) : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff               <= ST_CLEAR;
         clr_ff                 <= '0;
         cfg_input_count_ff     <= COUNT_WIDTH'(64);
         cfg_hidden_count_ff    <= COUNT_WIDTH'(64);
         cfg_batch_count_ff     <= BATCH_COUNT_WIDTH'(1);
         cfg_sequence_length_ff <= STEP_WIDTH'(1);
         cfg_output_steps_ff    <= STEP_WIDTH'(1);
         cfg_bias_enabled_ff    <= 1'b0;
         elem_ff                <= '0;
         batch_ff               <= '0;
         step_ff                <= '0;
         j_ff                   <= '0;
         k_ff                   <= '0;
         v1_ff                  <= 1'b0;
         v2_ff                  <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         elem_ff      <= elem_in;
         batch_ff     <= batch_in;
         step_ff      <= step_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INPUT_COUNT:     cfg_input_count_ff     <= csr_data[COUNT_WIDTH-1:0];
               REG_HIDDEN_COUNT:    cfg_hidden_count_ff    <= csr_data[COUNT_WIDTH-1:0];
               REG_BATCH_COUNT:     cfg_batch_count_ff     <= csr_data[BATCH_COUNT_WIDTH-1:0];
               REG_SEQUENCE_LENGTH: cfg_sequence_length_ff <= csr_data[STEP_WIDTH-1:0];
               REG_OUTPUT_STEPS:    cfg_output_steps_ff    <= csr_data[STEP_WIDTH-1:0];
               REG_BIAS_ENABLED:    cfg_bias_enabled_ff    <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_b_ff     <= cur_b_in;
      emit_ff      <= emit_in;
      is_sample_ff <= is_sample_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      sat_ff       <= sat_in;
      q_ff         <= q_in;
      lo_ff        <= lo_in;
      d_ff         <= d_in;
      fr_ff        <= fr_in;
      out_step_ff  <= out_step_in;
      out_batch_ff <= out_batch_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign req_ready        = state_ff == ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_index   = out_step_ff;
   assign rsp_batch_index  = out_batch_ff;
   assign rsp_hidden_index = out_index_ff;
   assign rsp_hidden_value = out_value_ff;
   assign rsp_last         = out_last_ff;

endmodule

@@ rtl/core/rtcs_checker.sv @@
// Port-level checker of the recurrent cell block and its bind statement.
`include "rnn_tanh_cell_sequence_macros.svh"

module rtcs_checker #(
   parameter int DATA_WIDTH = 16
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic [rtcs_pkg::STEP_WIDTH-1:0]          rsp_step_index,
   input logic [rtcs_pkg::BATCH_INDEX_WIDTH-1:0]   rsp_batch_index,
   input logic [rtcs_pkg::HIDDEN_INDEX_WIDTH-1:0]  rsp_hidden_index,
   input logic signed [DATA_WIDTH-1:0]             rsp_hidden_value,
   input logic                                     rsp_last
);
   import rtcs_pkg::*;

   `RTCS_ASSERT_ALW(a_reset_clears_rsp, clock, reset, !rsp_valid, "result valid after reset")

   `RTCS_ASSERT_IMP(a_no_take_while_rsp, clock, reset, rsp_valid, !req_ready,
                    "item taken while a result waits")

   `RTCS_ASSERT_IMP(a_value_in_range, clock, reset, rsp_valid,
                    $signed(rsp_hidden_value) <= ONE_Q && $signed(rsp_hidden_value) >= -ONE_Q,
                    "hidden value outside plus or minus one")

   `RTCS_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_hidden_value) && $stable(rsp_hidden_index)
                    && $stable(rsp_last) && $stable(rsp_step_index) && $stable(rsp_batch_index),
                    "stalled result changed")

endmodule

bind rnn_tanh_cell_sequence rtcs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rtcs_checker (.*);
